[sv/dasp_pkg.sv]
// Package for the abbreviation table stream parser: decoded value width,
// record kinds and the structs passed between the parser modules.
// No dependencies; compile first.
`default_nettype none

package dasp_pkg;

    // Width of a decoded ULEB128 value and of the shift count that walks it
    localparam int VALUE_BITS = 32;
    localparam int SHIFT_W    = $clog2(VALUE_BITS + 1);
    localparam int FIELD_W    = 32;

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [SHIFT_W-1:0]    shift_t;
    typedef logic [FIELD_W-1:0]    field_t;

    typedef enum logic [1:0] {
        KIND_HEADER    = 2'd0,
        KIND_ATTR      = 2'd1,
        KIND_END_ENTRY = 2'd2,
        KIND_END_TABLE = 2'd3
    } record_kind_t;

    // One byte folded into the ULEB128 accumulator
    typedef struct packed {
        value_t acc;
        shift_t shift;
        logic   ovf;
        logic   last;
    } leb_step_t;

    // One decoded record
    typedef struct packed {
        record_kind_t kind;
        field_t       abbrev_code;
        field_t       tag_value;
        logic         has_children;
        field_t       attr_name;
        field_t       attr_form;
        logic         overflow;
    } record_t;

endpackage

`default_nettype wire

[sv/dasp_in_if.sv]
// Byte channel of the abbreviation table parser: valid/ready plus one
// table byte and the start-of-table mark. No dependencies.
`default_nettype none

interface dasp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] section_byte;
    logic       start_table;

    modport source (output valid, output section_byte, output start_table, input ready);
    modport sink   (input valid, input section_byte, input start_table, output ready);
endinterface

`default_nettype wire

[sv/dasp_out_if.sv]
// Record channel of the abbreviation table parser: valid/ready plus the
// decoded record fields. Depends on dasp_pkg.
`default_nettype none

interface dasp_out_if;
    logic                   valid;
    logic                   ready;
    dasp_pkg::record_kind_t record_kind;
    dasp_pkg::field_t       abbrev_code;
    dasp_pkg::field_t       tag_value;
    logic                   has_children;
    dasp_pkg::field_t       attr_name;
    dasp_pkg::field_t       attr_form;
    logic                   overflow;

    modport source (output valid, output record_kind, output abbrev_code, output tag_value,
                    output has_children, output attr_name, output attr_form,
                    output overflow, input ready);
    modport sink   (input valid, input record_kind, input abbrev_code, input tag_value,
                    input has_children, input attr_name, input attr_form,
                    input overflow, output ready);
endinterface

`default_nettype wire

[sv/dasp_leb_step.sv]
// One ULEB128 decode step: places the 7 payload bits of a byte at the
// current shift, flags bits beyond VALUE_BITS. Depends on dasp_pkg.
`default_nettype none

module dasp_leb_step (
    input  var dasp_pkg::value_t    acc,
    input  var dasp_pkg::shift_t    shift,
    input  var logic [7:0]          data_byte,
    output var dasp_pkg::leb_step_t step
);
    import dasp_pkg::*;

    logic [VALUE_BITS+6:0] placed;
    logic [SHIFT_W:0]      shift_sum;

    // Place payload; anything landing at or above VALUE_BITS is overflow
    always_comb
    begin
        placed    = {{VALUE_BITS{1'b0}}, data_byte[6:0]} << shift;
        shift_sum = {1'b0, shift} + (SHIFT_W + 1)'(7);
        step.acc  = acc | placed[VALUE_BITS-1:0];
        step.ovf  = |placed[VALUE_BITS+6:VALUE_BITS];
        step.last = !data_byte[7];
        // Saturate the shift at the value width
        if (shift_sum > (SHIFT_W + 1)'(VALUE_BITS))
        begin
            step.shift = SHIFT_W'(VALUE_BITS);
        end
        else
        begin
            step.shift = shift_sum[SHIFT_W-1:0];
        end
    end

endmodule

`default_nettype wire

[sv/dasp_parser_fsm.sv]
// Phase machine of the abbreviation table parser: holds the decode state,
// takes one byte per step and forms at most one record. Depends on
// dasp_pkg and dasp_leb_step.
`default_nettype none

module dasp_parser_fsm (
    input  var logic               clk,
    input  var logic               rst_n,
    input  var logic               step_en,
    input  var logic [7:0]         data_byte,
    input  var logic               start,
    output var logic               res_valid,
    output var dasp_pkg::record_t  res
);
    import dasp_pkg::*;

    typedef enum logic [2:0] {
        PH_CODE,
        PH_TAG,
        PH_CHILD,
        PH_NAME,
        PH_FORM,
        PH_DONE
    } phase_t;

    phase_t    phase_reg, phase_cur, phase_next;
    value_t    acc_reg, acc_cur, acc_next;
    shift_t    shift_reg, shift_cur, shift_next;
    field_t    code_reg, code_cur, code_next;
    field_t    tag_reg, tag_cur, tag_next;
    logic      child_reg, child_cur, child_next;
    field_t    name_reg, name_cur, name_next;
    logic      ovf_reg, ovf_cur, ovf_next;
    leb_step_t leb;
    logic      feed;
    logic      emit;
    logic      ovf_fed;

    // Start of table clears the state before the byte is taken
    always_comb
    begin
        if (start)
        begin
            phase_cur = PH_CODE;
            acc_cur   = '0;
            shift_cur = '0;
            code_cur  = '0;
            tag_cur   = '0;
            child_cur = 1'b0;
            name_cur  = '0;
            ovf_cur   = 1'b0;
        end
        else
        begin
            phase_cur = phase_reg;
            acc_cur   = acc_reg;
            shift_cur = shift_reg;
            code_cur  = code_reg;
            tag_cur   = tag_reg;
            child_cur = child_reg;
            name_cur  = name_reg;
            ovf_cur   = ovf_reg;
        end
    end

    dasp_leb_step u_leb (
        .acc       (acc_cur),
        .shift     (shift_cur),
        .data_byte (data_byte),
        .step      (leb)
    );

    // Advance the phase and form the record
    always_comb
    begin
        feed = (phase_cur == PH_CODE) || (phase_cur == PH_TAG)
            || (phase_cur == PH_NAME) || (phase_cur == PH_FORM);
        phase_next = phase_cur;
        code_next  = code_cur;
        tag_next   = tag_cur;
        child_next = child_cur;
        name_next  = name_cur;
        acc_next   = acc_cur;
        shift_next = shift_cur;
        ovf_fed    = ovf_cur;
        emit       = 1'b0;
        res        = '0;

        if (feed)
        begin
            ovf_fed = ovf_cur | leb.ovf;
            if (leb.last)
            begin
                acc_next   = '0;
                shift_next = '0;
            end
            else
            begin
                acc_next   = leb.acc;
                shift_next = leb.shift;
            end
        end
        ovf_next = ovf_fed;

        unique case (phase_cur)
            PH_CODE:
            begin
                if (leb.last)
                begin
                    if (leb.acc == '0)
                    begin
                        phase_next = PH_DONE;
                        emit       = 1'b1;
                        res.kind   = KIND_END_TABLE;
                    end
                    else
                    begin
                        code_next  = FIELD_W'(leb.acc);
                        phase_next = PH_TAG;
                    end
                end
            end
            PH_TAG:
            begin
                if (leb.last)
                begin
                    tag_next   = FIELD_W'(leb.acc);
                    phase_next = PH_CHILD;
                end
            end
            PH_CHILD:
            begin
                child_next       = (data_byte != 8'd0);
                phase_next       = PH_NAME;
                emit             = 1'b1;
                res.kind         = KIND_HEADER;
                res.abbrev_code  = code_cur;
                res.tag_value    = tag_cur;
                res.has_children = child_next;
            end
            PH_NAME:
            begin
                if (leb.last)
                begin
                    name_next  = FIELD_W'(leb.acc);
                    phase_next = PH_FORM;
                end
            end
            PH_FORM:
            begin
                if (leb.last)
                begin
                    if (name_cur != '0)
                    begin
                        phase_next       = PH_NAME;
                        emit             = 1'b1;
                        res.kind         = KIND_ATTR;
                        res.abbrev_code  = code_cur;
                        res.tag_value    = tag_cur;
                        res.has_children = child_cur;
                        res.attr_name    = name_cur;
                        res.attr_form    = FIELD_W'(leb.acc);
                    end
                    else if (leb.acc == '0)
                    begin
                        phase_next       = PH_CODE;
                        emit             = 1'b1;
                        res.kind         = KIND_END_ENTRY;
                        res.abbrev_code  = code_cur;
                        res.tag_value    = tag_cur;
                        res.has_children = child_cur;
                    end
                    else
                    begin
                        // Null name with a form: drop the pair and its overflow
                        phase_next = PH_NAME;
                        ovf_next   = 1'b0;
                    end
                end
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        // A record reports and clears the overflow seen so far
        if (emit)
        begin
            res.overflow = ovf_fed;
            ovf_next     = 1'b0;
        end
        res_valid = step_en && emit;
    end

    // Hold the decode state; update only on a step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CODE;
            acc_reg   <= '0;
            shift_reg <= '0;
            code_reg  <= '0;
            tag_reg   <= '0;
            child_reg <= 1'b0;
            name_reg  <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            shift_reg <= shift_next;
            code_reg  <= code_next;
            tag_reg   <= tag_next;
            child_reg <= child_next;
            name_reg  <= name_next;
            ovf_reg   <= ovf_next;
        end
    end

`ifndef SYNTHESIS
    a_shift_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        shift_reg <= SHIFT_W'(VALUE_BITS))
        else $error("ULEB shift beyond value width");

    a_attr_named: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.kind == KIND_ATTR) |-> res.attr_name != '0)
        else $error("attribute record with null name");

    a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && !start && (phase_reg == PH_DONE) |=> phase_reg == PH_DONE)
        else $error("parser left end of table without restart");

    a_end_table_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.kind == KIND_END_TABLE) |=> phase_reg == PH_DONE)
        else $error("end of table without entering done phase");

    a_child_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_CHILD) |-> (shift_reg == '0) && (acc_reg == '0))
        else $error("accumulator not cleared before children byte");
`endif

endmodule

`default_nettype wire

[sv/dwarf_abbrev_stream_parser_unit.sv]
// Abbreviation table stream parser, top level: input register, phase
// machine, result register. Depends on dasp_pkg, dasp_in_if, dasp_out_if,
// dasp_parser_fsm.
//
// Usage:
//   abbrev_bytes carries one table byte per request; start_table high marks
//   the first byte of a table and restarts decoding with that byte.
//   records carries one decoded record per request: entry header, attribute
//   pair, end of entry or end of table. Most bytes give no record.
//   Throughput: one byte per cycle while records is not stalled, set by the
//   combinational ULEB128 step and phase update between the two registers.
//   Path: the byte that completes a record is taken into the input register,
//   decoded out of it, and the record lands in the result register, which
//   presents it on records.
//   Stall: while a record waits on records, one more byte is taken into
//   the input register; further bytes wait until the record is taken.
//   Reset: rst_n clears both registers and sets the parser to expect an
//   abbreviation code; after an end-of-table record bytes are dropped
//   until start_table is seen.
`default_nettype none

module dwarf_abbrev_stream_parser_unit (
    input  var logic clk,
    input  var logic rst_n,
    dasp_in_if.sink  abbrev_bytes,
    dasp_out_if.source records
);
    import dasp_pkg::*;

    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       start_reg;
    logic       out_valid_reg;
    record_t    out_rec_reg;
    logic       advance;
    logic       step_en;
    logic       res_valid;
    record_t    res;

    // Move when the result register is free or being drained
    assign advance            = !out_valid_reg || records.ready;
    assign abbrev_bytes.ready = !in_valid_reg || advance;
    assign step_en            = in_valid_reg && advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (abbrev_bytes.ready)
        begin
            in_valid_reg <= abbrev_bytes.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (abbrev_bytes.valid && abbrev_bytes.ready)
        begin
            byte_reg  <= abbrev_bytes.section_byte;
            start_reg <= abbrev_bytes.start_table;
        end
    end

    dasp_parser_fsm u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .data_byte (byte_reg),
        .start     (start_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_rec_reg <= res;
        end
    end

    // Drive the record channel
    assign records.valid        = out_valid_reg;
    assign records.record_kind  = out_rec_reg.kind;
    assign records.abbrev_code  = out_rec_reg.abbrev_code;
    assign records.tag_value    = out_rec_reg.tag_value;
    assign records.has_children = out_rec_reg.has_children;
    assign records.attr_name    = out_rec_reg.attr_name;
    assign records.attr_form    = out_rec_reg.attr_form;
    assign records.overflow     = out_rec_reg.overflow;

endmodule

`default_nettype wire

[dv/dwarf_abbrev_stream_parser_unit_test.sv]
// Self-checking test of the abbreviation table stream parser: byte-level
// ULEB128 decode predictor, record checker and handshake drivers.
// Depends on dasp_pkg, dasp_in_if, dasp_out_if and the parser top level.

typedef enum logic [2:0] {
    AWAIT_CODE,
    AWAIT_TAG,
    AWAIT_CHILDREN,
    AWAIT_NAME,
    AWAIT_FORM,
    TABLE_CLOSED
} parse_phase_t;

// Tracks the parse of the byte stream and holds the records it must produce
class abbrev_record_tracker;
    parse_phase_t          phase;
    logic [63:0]           acc;
    int unsigned           shift;
    dasp_pkg::field_t      code_q;
    dasp_pkg::field_t      tag_q;
    dasp_pkg::field_t      name_q;
    logic                  children_q;
    logic                  ovf_q;
    dasp_pkg::record_t     pending_records[$];
    int unsigned           mismatches;

    function new();
        clear();
        mismatches = 0;
    endfunction

    function void clear();
        phase      = AWAIT_CODE;
        acc        = '0;
        shift      = 0;
        code_q     = '0;
        tag_q      = '0;
        name_q     = '0;
        children_q = 1'b0;
        ovf_q      = 1'b0;
    endfunction

    function logic [63:0] keep_mask();
        if (dasp_pkg::VALUE_BITS >= 64)
            return '1;
        return (64'd1 << dasp_pkg::VALUE_BITS) - 64'd1;
    endfunction

    // Fold one byte into the accumulator; return 1 on the last byte of a field
    function bit feed_leb(logic [7:0] b);
        logic [63:0] payload;
        int unsigned room;
        payload = {57'd0, b[6:0]};
        if (shift >= dasp_pkg::VALUE_BITS) begin
            if (payload != 0)
                ovf_q = 1'b1;
        end
        else begin
            room = dasp_pkg::VALUE_BITS - shift;
            if (room < 7 && (payload >> room) != 0)
                ovf_q = 1'b1;
            acc = (acc | (payload << shift)) & keep_mask();
            shift = shift + 7;
            if (shift > dasp_pkg::VALUE_BITS)
                shift = dasp_pkg::VALUE_BITS;
        end
        return !b[7];
    endfunction

    function logic [63:0] take_leb();
        logic [63:0] v;
        v = acc;
        acc = '0;
        shift = 0;
        return v;
    endfunction

    function void push_record(dasp_pkg::record_kind_t kind, dasp_pkg::field_t code,
                              dasp_pkg::field_t tag, logic ch,
                              dasp_pkg::field_t name, dasp_pkg::field_t form);
        dasp_pkg::record_t r;
        r.kind         = kind;
        r.abbrev_code  = code;
        r.tag_value    = tag;
        r.has_children = ch;
        r.attr_name    = name;
        r.attr_form    = form;
        r.overflow     = ovf_q;
        ovf_q = 1'b0;
        pending_records.push_back(r);
    endfunction

    // Advance the parse by one accepted request
    function void take_byte(logic [7:0] b, logic st);
        logic [63:0] v;
        if (st)
            clear();
        case (phase)
            AWAIT_CODE: begin
                if (feed_leb(b)) begin
                    v = take_leb();
                    if (v == 0) begin
                        phase = TABLE_CLOSED;
                        push_record(dasp_pkg::KIND_END_TABLE, '0, '0, 1'b0, '0, '0);
                    end
                    else begin
                        code_q = v[31:0];
                        phase  = AWAIT_TAG;
                    end
                end
            end
            AWAIT_TAG: begin
                if (feed_leb(b)) begin
                    v = take_leb();
                    tag_q = v[31:0];
                    phase = AWAIT_CHILDREN;
                end
            end
            AWAIT_CHILDREN: begin
                children_q = (b != 8'h00);
                phase = AWAIT_NAME;
                push_record(dasp_pkg::KIND_HEADER, code_q, tag_q, children_q, '0, '0);
            end
            AWAIT_NAME: begin
                if (feed_leb(b)) begin
                    v = take_leb();
                    name_q = v[31:0];
                    phase  = AWAIT_FORM;
                end
            end
            AWAIT_FORM: begin
                if (feed_leb(b)) begin
                    v = take_leb();
                    if (name_q != 0) begin
                        phase = AWAIT_NAME;
                        push_record(dasp_pkg::KIND_ATTR, code_q, tag_q, children_q,
                                    name_q, v[31:0]);
                    end
                    else if (v == 0) begin
                        phase = AWAIT_CODE;
                        push_record(dasp_pkg::KIND_END_ENTRY, code_q, tag_q, children_q,
                                    '0, '0);
                    end
                    else begin
                        // drop a null-name pair and its overflow
                        ovf_q = 1'b0;
                        phase = AWAIT_NAME;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Compare one accepted record with the oldest one predicted
    function void match_record(dasp_pkg::record_t got);
        dasp_pkg::record_t exp;
        if (pending_records.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected record: kind=%0d code=%h tag=%h ch=%0d name=%h form=%h ovf=%0d",
                         got.kind, got.abbrev_code, got.tag_value, got.has_children,
                         got.attr_name, got.attr_form, got.overflow);
            return;
        end
        exp = pending_records.pop_front();
        if (got.kind !== exp.kind || got.abbrev_code !== exp.abbrev_code ||
            got.tag_value !== exp.tag_value || got.has_children !== exp.has_children ||
            got.attr_name !== exp.attr_name || got.attr_form !== exp.attr_form ||
            got.overflow !== exp.overflow) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("record mismatch: exp kind=%0d code=%h tag=%h ch=%0d name=%h form=%h ovf=%0d",
                         exp.kind, exp.abbrev_code, exp.tag_value, exp.has_children,
                         exp.attr_name, exp.attr_form, exp.overflow);
                $display("                 got kind=%0d code=%h tag=%h ch=%0d name=%h form=%h ovf=%0d",
                         got.kind, got.abbrev_code, got.tag_value, got.has_children,
                         got.attr_name, got.attr_form, got.overflow);
            end
        end
    endfunction
endclass

module dwarf_abbrev_stream_parser_unit_test;
    import dasp_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_ITEMS = 2000;

    typedef struct {
        logic [7:0] data;
        logic       first;
    } stream_byte_t;

    logic clk;
    logic rst_n;
    bit   steady;
    bit   mark_start;
    int unsigned cycles;
    stream_byte_t table_bytes[$];
    abbrev_record_tracker tracker;

    dasp_in_if  abbrev_bytes_if();
    dasp_out_if records_if();

    dwarf_abbrev_stream_parser_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .abbrev_bytes (abbrev_bytes_if),
        .records      (records_if)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Abort a run that hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Stall the record channel at random, except in the steady stretch
    initial
    begin
        records_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            records_if.ready <= steady || ($urandom_range(99) >= 16);
        end
    end

    // Feed accepted bytes into the predictor
    always @(posedge clk)
    begin
        if (rst_n && abbrev_bytes_if.valid && abbrev_bytes_if.ready)
            tracker.take_byte(abbrev_bytes_if.section_byte, abbrev_bytes_if.start_table);
    end

    // Check accepted records
    always @(posedge clk)
    begin
        record_t got;
        if (rst_n && records_if.valid && records_if.ready)
        begin
            got.kind         = records_if.record_kind;
            got.abbrev_code  = records_if.abbrev_code;
            got.tag_value    = records_if.tag_value;
            got.has_children = records_if.has_children;
            got.attr_name    = records_if.attr_name;
            got.attr_form    = records_if.attr_form;
            got.overflow     = records_if.overflow;
            tracker.match_record(got);
        end
    end

    // Append one byte; the start mark goes on the first byte after it is set
    function automatic void add_byte(logic [7:0] b);
        stream_byte_t e;
        e.data  = b;
        e.first = mark_start;
        mark_start = 1'b0;
        table_bytes.push_back(e);
    endfunction

    // Append a ULEB128 field, padded with pad extra zero-payload bytes
    function automatic void add_leb(logic [63:0] v, int unsigned pad);
        int unsigned n;
        logic [63:0] rest;
        logic [63:0] part;
        logic [7:0]  g;
        n = 1;
        rest = v >> 7;
        while (rest != 0)
        begin
            n++;
            rest = rest >> 7;
        end
        n = n + pad;
        for (int unsigned i = 0; i < n; i++)
        begin
            part = (i * 7 < 64) ? (v >> (i * 7)) : 64'd0;
            g = {1'b0, part[6:0]};
            if (i < n - 1)
                g[7] = 1'b1;
            add_byte(g);
        end
    endfunction

    // Mostly short values, some full width, some past the value width
    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = $urandom_range(127);
            4, 5:       v = $urandom_range(16383);
            6:          v = {32'd0, $urandom};
            7:          v = {$urandom, $urandom} >> $urandom_range(63);
            8:          v = {$urandom, $urandom};
            default:    v = $urandom_range(3);
        endcase
        return v;
    endfunction

    function automatic int unsigned rand_pad();
        return ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    // Append one entry: code, tag, children byte, pairs, closing null pair
    function automatic void add_entry();
        logic [63:0] code;
        logic [63:0] name;
        int unsigned pairs;
        code = rand_value();
        if ((code & tracker.keep_mask()) == 0)
            code[0] = 1'b1;
        add_leb(code, rand_pad());
        add_leb(rand_value(), rand_pad());
        add_byte(($urandom_range(1) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
        pairs = $urandom_range(5);
        for (int unsigned i = 0; i < pairs; i++)
        begin
            if ($urandom_range(9) == 0)
            begin
                add_leb(64'd0, rand_pad());
                add_leb(rand_value() | 64'd1, rand_pad());
            end
            else
            begin
                name = rand_value();
                if (name == 0)
                    name = 64'd1;
                add_leb(name, rand_pad());
                add_leb(rand_value(), rand_pad());
            end
        end
        add_leb(64'd0, rand_pad());
        add_leb(64'd0, rand_pad());
    endfunction

    // Build a whole table, closed by a code that decodes to zero
    function automatic void build_table();
        int unsigned entries;
        table_bytes.delete();
        mark_start = 1'b1;
        entries = $urandom_range(1, 3);
        for (int unsigned i = 0; i < entries; i++)
            add_entry();
        if ($urandom_range(9) == 0 && VALUE_BITS < 61)
            add_leb(64'd1 << (VALUE_BITS + $urandom_range(3)), 0);
        else
            add_leb(64'd0, rand_pad());
    endfunction

    // Present one request and hold it until taken
    task automatic send_byte(logic [7:0] b, logic st);
        while (!steady && $urandom_range(99) < 16)
        begin
            @(negedge clk);
            abbrev_bytes_if.valid <= 1'b0;
        end
        @(negedge clk);
        abbrev_bytes_if.valid        <= 1'b1;
        abbrev_bytes_if.section_byte <= b;
        abbrev_bytes_if.start_table  <= st;
        @(posedge clk);
        while (!abbrev_bytes_if.ready)
            @(posedge clk);
    endtask

    task automatic send_table();
        foreach (table_bytes[i])
            send_byte(table_bytes[i].data, table_bytes[i].first);
    endtask

    // Drop valid and wait for every predicted record
    task automatic hold_until_drained();
        @(negedge clk);
        abbrev_bytes_if.valid <= 1'b0;
        while (tracker.pending_records.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned sent;
        int unsigned mode;
        int unsigned keep;
        int unsigned count;
        bit paused;
        tracker = new();
        cycles = 0;
        steady = 1'b0;
        mark_start = 1'b0;
        rst_n = 1'b0;
        abbrev_bytes_if.valid        = 1'b0;
        abbrev_bytes_if.section_byte = 8'h00;
        abbrev_bytes_if.start_table  = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: plain entry, null-name skip, full-width code,
        // overlong tag, end of table, ignored byte, truncated zero code
        table_bytes.delete();
        mark_start = 1'b1;
        add_leb(64'd1, 0);
        add_leb(64'h11, 0);
        add_byte(8'h01);
        add_leb(64'd3, 0);
        add_leb(64'd8, 0);
        add_leb(64'd0, 0);
        add_leb(64'd5, 0);
        add_leb(64'd0, 0);
        add_leb(64'd0, 0);
        add_leb(64'hFFFF_FFFF, 0);
        add_leb(64'h7_FFFF_FFFF, 0);
        add_byte(8'h00);
        add_leb(64'd0, 0);
        add_leb(64'd0, 0);
        add_leb(64'd0, 0);
        add_byte(8'hFF);
        mark_start = 1'b1;
        add_leb(64'h1_0000_0000, 0);
        send_table();
        hold_until_drained();

        // Random: mostly whole tables, some cut short, some raw noise
        sent = 0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            steady = (sent >= 800 && sent < 1100);
            if (!paused && sent >= 1400)
            begin
                hold_until_drained();
                paused = 1'b1;
            end
            mode = $urandom_range(99);
            if (mode < 80)
            begin
                build_table();
                sent += table_bytes.size();
                send_table();
                // trailing bytes after the end of table are ignored
                table_bytes.delete();
                count = $urandom_range(2);
                for (int unsigned i = 0; i < count; i++)
                    add_byte(8'($urandom_range(255)));
                send_table();
            end
            else if (mode < 90)
            begin
                build_table();
                keep = $urandom_range(1, table_bytes.size());
                while (table_bytes.size() > keep)
                    void'(table_bytes.pop_back());
                sent += keep;
                send_table();
            end
            else
            begin
                table_bytes.delete();
                count = $urandom_range(1, 16);
                for (int unsigned i = 0; i < count; i++)
                begin
                    mark_start = ($urandom_range(9) == 0);
                    add_byte(8'($urandom_range(255)));
                end
                sent += count;
                send_table();
            end
        end
        steady = 1'b0;

        hold_until_drained();
        repeat (20) @(posedge clk);
        if (tracker.pending_records.size() != 0)
            $display("%0d predicted records never arrived", tracker.pending_records.size());
        if (tracker.mismatches == 0 && tracker.pending_records.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
